// ----- hdl/pet_pkg.sv -----
`default_nettype none

package pet_pkg;

    // Default number of tracked exception vectors.
    localparam int NUM_VECTORS_DEF = 32;

    // Widths of the transfer fields.
    localparam int ACTION_W = 2;
    localparam int VECTOR_W = 5;
    localparam int CODE_W   = 32;

    // Input transfer layout: action, vector, exc_code from the lowest bit up.
    localparam int IN_ACTION_LSB = 0;
    localparam int IN_VECTOR_LSB = IN_ACTION_LSB + ACTION_W;
    localparam int IN_CODE_LSB   = IN_VECTOR_LSB + VECTOR_W;
    localparam int IN_FIELDS_W   = IN_CODE_LSB + CODE_W;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

    // Output transfer layout: status, any_pending, next_vector,
    // vector_has_error, vector_error_code from the lowest bit up.
    localparam int OUT_FIELDS_W = 1 + 1 + VECTOR_W + 1 + CODE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Actions on one vector.
    typedef enum logic [ACTION_W-1:0] {
        ACT_QUERY     = 2'd0,
        ACT_RAISE     = 2'd1,
        ACT_RAISE_ERR = 2'd2,
        ACT_CLEAR     = 2'd3
    } action_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the input transfer and start the store read
        logic exec;      // apply the action and load the result register
    } dp_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/pet_ram.sv -----
`default_nettype none

module pet_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pet_ctrl.sv -----
`default_nettype none

module pet_ctrl
    import pet_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output dp_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/pet_dp.sv -----
`default_nettype none

module pet_dp
    import pet_pkg::*;
#(
    parameter int NUM_VECTORS = NUM_VECTORS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dp_cmd_t                 cmd,
    input  wire logic [IN_FIELDS_W-1:0]  in_fields,
    output logic      [OUT_TDATA_W-1:0]  out_tdata
);

    localparam int VW = $clog2(NUM_VECTORS);
    localparam int WW = VW + VECTOR_W;

    // Latched input transfer.
    action_t             action_reg;
    logic [VECTOR_W-1:0] vector_reg;
    logic [CODE_W-1:0]   code_reg;

    // Flag state and the written marks of the error code store.
    logic [NUM_VECTORS-1:0] pending_reg;
    logic [NUM_VECTORS-1:0] pending_next;
    logic [NUM_VECTORS-1:0] error_reg;
    logic [NUM_VECTORS-1:0] error_next;
    logic [NUM_VECTORS-1:0] written_reg;
    logic [NUM_VECTORS-1:0] written_next;

    logic [OUT_TDATA_W-1:0] out_reg;
    logic [OUT_TDATA_W-1:0] out_next;

    logic [WW-1:0]       in_vec_wide;
    logic [WW-1:0]       vec_wide;
    logic [VW-1:0]       idx;
    logic                in_range;
    logic [CODE_W-1:0]   ram_rdata;
    logic                ram_we;
    logic                status;
    logic                has_err;
    logic [CODE_W-1:0]   stored;
    logic [VW-1:0]       enc;
    logic [WW-1:0]       enc_wide;

    // Vector index into the flag vectors and the store.
    assign in_vec_wide = {{VW{1'b0}}, in_fields[IN_VECTOR_LSB +: VECTOR_W]};
    assign vec_wide    = {{VW{1'b0}}, vector_reg};
    assign idx         = vec_wide[VW-1:0];
    assign in_range    = (vec_wide < WW'(NUM_VECTORS));

    // Input capture and result register; payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action_t'(in_fields[IN_ACTION_LSB +: ACTION_W]);
            vector_reg <= in_fields[IN_VECTOR_LSB +: VECTOR_W];
            code_reg   <= in_fields[IN_CODE_LSB +: CODE_W];
        end
        if (cmd.exec)
        begin
            out_reg <= out_next;
        end
    end

    // Error code store, read at capture, written when a raise with error code is applied.
    pet_ram #(
        .WIDTH (CODE_W),
        .DEPTH (NUM_VECTORS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (code_reg),
        .re    (cmd.capture),
        .raddr (in_vec_wide[VW-1:0]),
        .rdata (ram_rdata)
    );

    // Apply the action to the flags.
    always_comb
    begin
        pending_next = pending_reg;
        error_next   = error_reg;
        written_next = written_reg;
        status       = 1'b0;
        ram_we       = 1'b0;
        if (in_range)
        begin
            unique case (action_reg)
                ACT_QUERY:
                begin
                end
                ACT_RAISE:
                begin
                    if (pending_reg[idx])
                    begin
                        status = 1'b1;
                    end
                    else
                    begin
                        pending_next[idx] = 1'b1;
                    end
                end
                ACT_RAISE_ERR:
                begin
                    if (pending_reg[idx])
                    begin
                        status = 1'b1;
                    end
                    else
                    begin
                        pending_next[idx] = 1'b1;
                        error_next[idx]   = 1'b1;
                        written_next[idx] = 1'b1;
                        ram_we            = cmd.exec;
                    end
                end
                ACT_CLEAR:
                begin
                    pending_next[idx] = 1'b0;
                    error_next[idx]   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Lowest pending vector after the step.
    always_comb
    begin
        enc = '0;
        for (int i = NUM_VECTORS - 1; i >= 0; i--)
        begin
            if (pending_next[i])
            begin
                enc = VW'(i);
            end
        end
    end

    assign enc_wide = {{VECTOR_W{1'b0}}, enc};

    // Error flag and stored code of the addressed vector after the step.
    always_comb
    begin
        has_err = 1'b0;
        stored  = '0;
        if (in_range)
        begin
            has_err = error_next[idx];
            if (ram_we)
            begin
                stored = code_reg;
            end
            else if (written_reg[idx])
            begin
                stored = ram_rdata;
            end
        end
    end

    assign out_next = OUT_TDATA_W'({stored, has_err, enc_wide[VECTOR_W-1:0],
                                    |pending_next, status});

    // Flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            error_reg   <= '0;
            written_reg <= '0;
        end
        else if (cmd.exec)
        begin
            pending_reg <= pending_next;
            error_reg   <= error_next;
            written_reg <= written_next;
        end
    end

    assign out_tdata = out_reg;

endmodule

`default_nettype wire

// ----- hdl/pending_exception_tracker.sv -----
// An accepted input goes through the execute state to the output state, which
// offers the result; no new action is taken until the result is handed off.
// The steps are the store read, the flag update and the output hand-off.
// Reset (rst_n, asynchronous, active low) clears all pending and error flags
// and marks every stored error code as zero; no clearing pass is needed.
`default_nettype none

module pending_exception_tracker
    import pet_pkg::*;
#(
    parameter int NUM_VECTORS = NUM_VECTORS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // action[1:0], vector[6:2], exc_code[38:7], zero fill above
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status[0], any_pending[1], next_vector[6:2], vector_has_error[7],
    // vector_error_code[39:8]
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    dp_cmd_t cmd;

    // Sequencing of one action at a time.
    pet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // Flags, error code store and result register.
    pet_dp #(
        .NUM_VECTORS (NUM_VECTORS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_fields (s_axis_tdata[IN_FIELDS_W-1:0]),
        .out_tdata (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- hdl/pet_checker.sv -----
`default_nettype none

module pet_checker
    import pet_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Every accepted action is answered, with the result offered after the execute state.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("result missing two cycles after accept");

    // No new action is taken while a result is on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    // With nothing pending the reported vector is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[6:2] == 5'd0)
        else $error("next vector set with nothing pending");

    // A refused raise means the vector is pending, so something is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("refused raise with nothing pending");

endmodule

bind pending_exception_tracker pet_checker u_pet_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
